### rtl/tbpc_pkg.sv
// shared types and constants of the touch button press classifier
package tbpc_pkg;

  // field and state widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned SUM_W    = 21;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_DIGITAL_EN  = 3'd0;
  localparam logic [2:0] REG_TOUCH_EN    = 3'd1;
  localparam logic [2:0] REG_TOUCH_THR   = 3'd2;
  localparam logic [2:0] REG_LONG_MS     = 3'd3;
  localparam logic [2:0] REG_SHORT_MS    = 3'd4;

  // register reset values
  localparam logic [SAMPLE_W-1:0] RST_TOUCH_THR = 16'd0;
  localparam logic [SAMPLE_W-1:0] RST_LONG_MS   = 16'd800;
  localparam logic [SAMPLE_W-1:0] RST_SHORT_MS  = 16'd40;

  // settings that the press logic reads every item
  typedef struct packed {
    logic                digital_enable;
    logic                touch_enable;
    logic [SAMPLE_W-1:0] long_press_ms;
    logic [SAMPLE_W-1:0] short_press_ms;
  } cfg_t;

  // threshold register write toward the core
  typedef struct packed {
    logic                wr;
    logic [SAMPLE_W-1:0] value;
  } thr_wr_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_RUN    = 3'b001,
    ST_DIV    = 3'b010,
    ST_SETTLE = 3'b100
  } state_e;

endpackage

### rtl/tbpc_cfg.sv
// apb register bank of the touch button press classifier
module tbpc_cfg
  import tbpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o,
  output thr_wr_t           thr_wr_o
);

  logic                wr_en;
  logic [2:0]          idx;
  logic                dig_en_q;
  logic                touch_en_q;
  logic [SAMPLE_W-1:0] thr_q;
  logic [SAMPLE_W-1:0] long_q;
  logic [SAMPLE_W-1:0] short_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_en_q   <= 1'b1;
      touch_en_q <= 1'b1;
      thr_q      <= RST_TOUCH_THR;
      long_q     <= RST_LONG_MS;
      short_q    <= RST_SHORT_MS;
    end else if (wr_en) begin
      case (idx)
        REG_DIGITAL_EN: dig_en_q   <= pwdata[0];
        REG_TOUCH_EN:   touch_en_q <= pwdata[0];
        REG_TOUCH_THR:  thr_q      <= pwdata[SAMPLE_W-1:0];
        REG_LONG_MS:    long_q     <= pwdata[SAMPLE_W-1:0];
        REG_SHORT_MS:   short_q    <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    case (idx)
      REG_DIGITAL_EN: prdata = {31'd0, dig_en_q};
      REG_TOUCH_EN:   prdata = {31'd0, touch_en_q};
      REG_TOUCH_THR:  prdata = {16'd0, thr_q};
      REG_LONG_MS:    prdata = {16'd0, long_q};
      REG_SHORT_MS:   prdata = {16'd0, short_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.digital_enable = dig_en_q;
  assign cfg_o.touch_enable   = touch_en_q;
  assign cfg_o.long_press_ms  = long_q;
  assign cfg_o.short_press_ms = short_q;

  // threshold write also restarts calibration in the core
  assign thr_wr_o.wr    = wr_en && (idx == REG_TOUCH_THR);
  assign thr_wr_o.value = pwdata[SAMPLE_W-1:0];

endmodule

### rtl/tbpc_hyst.sv
// release level register: threshold plus clamped threshold/20 hysteresis
module tbpc_hyst
  import tbpc_pkg::*;
(
  input  logic                clk_i,
  input  logic [SAMPLE_W-1:0] thr_i,
  output logic [SAMPLE_W-1:0] release_lvl_o
);

  // x/20 for 16-bit x as (x * ceil(2^21/20)) >> 21
  localparam int unsigned    DIV_SHIFT = 21;
  localparam logic [16:0]    DIV_RECIP = 17'd104858;
  localparam logic [SAMPLE_W-1:0] HYST_MIN = 16'd30;
  localparam logic [SAMPLE_W-1:0] HYST_MAX = 16'd1500;

  logic [33:0]         prod;
  logic [SAMPLE_W-1:0] quot;
  logic [SAMPLE_W-1:0] hyst;
  logic [SAMPLE_W-1:0] lvl_q;

  assign prod = {18'd0, thr_i} * {17'd0, DIV_RECIP};
  assign quot = {3'd0, prod[33:DIV_SHIFT]};

  // clamp to the hysteresis window
  always_comb begin
    if (quot < HYST_MIN) begin
      hyst = HYST_MIN;
    end else if (quot > HYST_MAX) begin
      hyst = HYST_MAX;
    end else begin
      hyst = quot;
    end
  end

  // release level wraps at 16 bits
  always_ff @(posedge clk_i) begin
    lvl_q <= thr_i + hyst;
  end

  assign release_lvl_o = lvl_q;

endmodule

### rtl/tbpc_calib.sv
// calibration average and derived press threshold
module tbpc_calib
  import tbpc_pkg::*;
#(
  parameter int unsigned CALIB_SAMPLES = 20
) (
  input  logic [SUM_W-1:0]    sum_i,
  output logic [SAMPLE_W-1:0] thr_o
);

  // sum/N as (sum * ceil(2^S/N)) >> S, exact for sums below 2^SUM_W
  localparam int unsigned     DIV_SHIFT = SUM_W + $clog2(CALIB_SAMPLES);
  localparam longint unsigned RECIP_L   =
    ((64'd1 << DIV_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
  localparam int unsigned     RECIP_W   = SUM_W + 1;
  localparam int unsigned     PROD_W    = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_L);

  localparam logic [SAMPLE_W-1:0] MARGIN_MIN = 16'd200;
  localparam logic [SAMPLE_W-1:0] MARGIN_MAX = 16'd8000;

  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] base;
  logic [SAMPLE_W-1:0] margin_raw;
  logic [SAMPLE_W-1:0] margin;

  assign prod = {{RECIP_W{1'b0}}, sum_i} * {{SUM_W{1'b0}}, RECIP};
  assign base = prod[DIV_SHIFT +: SAMPLE_W];
  assign margin_raw = base >> 3;

  // clamp the margin, then step below the average
  always_comb begin
    if (margin_raw < MARGIN_MIN) begin
      margin = MARGIN_MIN;
    end else if (margin_raw > MARGIN_MAX) begin
      margin = MARGIN_MAX;
    end else begin
      margin = margin_raw;
    end
    if (base > margin) begin
      thr_o = base - margin;
    end else begin
      thr_o = 16'd1;
    end
  end

endmodule

### rtl/touch_button_press_classifier_core.sv
// top level of the touch button press classifier
//
// Input channel (in_valid_i/in_ready_o) takes one item per cycle unless held: a ms
// timestamp, the active-low button level and a touch sample. Output channel
// (out_valid_o/out_ready_i) gives one result per item, in order: short or
// long press on release, the pressed decision, the kept touch sample, the
// calibration flag and the threshold in use.
// An item passes an input register and the press logic into the output
// register, which raises out_valid_o; while neither the receiver nor the
// sequencer holds the flow, one item per cycle.
// The item that completes auto-calibration passes ST_DIV for the average
// division, then ST_SETTLE holds the input side while the release level
// register follows the new threshold; only that item is slowed. A
// threshold write holds the input side in ST_SETTLE for the same reason.
// A stalled receiver holds the result in the output register; the input
// register takes one more item and then in_ready_o drops.
// Reset clears the control and press state: threshold 0, so calibration
// starts with the first CALIB_SAMPLES touch samples. Registers are to be
// written over the APB port while the block is idle; the block does not
// enforce this. A threshold write restarts calibration.
module touch_button_press_classifier_core
  import tbpc_pkg::*;
#(
  parameter int unsigned CALIB_SAMPLES = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [TIME_W-1:0]   now_ms_i,
  input  logic                button_low_i,
  input  logic [SAMPLE_W-1:0] touch_sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                short_press_o,
  output logic                long_press_o,
  output logic                pressed_now_o,
  output logic [SAMPLE_W-1:0] touch_level_o,
  output logic                calibrating_o,
  output logic [SAMPLE_W-1:0] active_threshold_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam logic [CNT_W-1:0] CALIB_CNT = CNT_W'(CALIB_SAMPLES);

  cfg_t    cfg;
  thr_wr_t thr_wr;

  state_e state_q;

  // input register
  logic                in_valid_q;
  logic [TIME_W-1:0]   in_now_q;
  logic                in_btn_q;
  logic [SAMPLE_W-1:0] in_sample_q;

  // press state
  logic                was_pressed_q;
  logic [TIME_W-1:0]   press_start_q;
  logic [SAMPLE_W-1:0] last_touch_q;
  logic [SAMPLE_W-1:0] eff_thr_q;
  logic [SUM_W-1:0]    calib_sum_q;
  logic [CNT_W-1:0]    calib_cnt_q;
  logic [SUM_W-1:0]    fin_sum_q;

  // output register
  logic                out_valid_q;
  logic                out_short_q;
  logic                out_long_q;
  logic                out_pressed_q;
  logic [SAMPLE_W-1:0] out_touch_q;
  logic                out_calib_q;
  logic [SAMPLE_W-1:0] out_thr_q;

  logic                can_out;
  logic                advance;
  logic [SAMPLE_W-1:0] release_lvl;
  logic [SAMPLE_W-1:0] div_thr;
  logic                thr_zero;
  logic                calib_now;
  logic [SAMPLE_W-1:0] level;
  logic                touch_hit;
  logic                pressed;
  logic [SUM_W-1:0]    sum_new;
  logic [CNT_W-1:0]    cnt_new;
  logic                calib_done;
  logic [TIME_W-1:0]   dur;
  logic                released;
  logic                long_hit;
  logic                short_hit;
  logic [SAMPLE_W-1:0] touch_next;

  tbpc_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg_o    (cfg),
    .thr_wr_o (thr_wr)
  );

  tbpc_hyst u_hyst (
    .clk_i         (clk_i),
    .thr_i         (eff_thr_q),
    .release_lvl_o (release_lvl)
  );

  tbpc_calib #(
    .CALIB_SAMPLES (CALIB_SAMPLES)
  ) u_calib (
    .sum_i (fin_sum_q),
    .thr_o (div_thr)
  );

  // handshake
  assign can_out    = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && can_out && (state_q == ST_RUN);
  assign in_ready_o = !in_valid_q || advance;

  // press decision and calibration step
  assign thr_zero   = (eff_thr_q == '0);
  assign calib_now  = cfg.touch_enable && thr_zero;
  assign level      = was_pressed_q ? release_lvl : eff_thr_q;
  assign touch_hit  = cfg.touch_enable && !thr_zero && (in_sample_q < level);
  assign pressed    = (cfg.digital_enable && in_btn_q) || touch_hit;
  assign sum_new    = calib_sum_q + SUM_W'(in_sample_q);
  assign cnt_new    = calib_cnt_q + CNT_W'(1);
  assign calib_done = calib_now && (cnt_new >= CALIB_CNT);
  assign touch_next = cfg.touch_enable ? in_sample_q : last_touch_q;

  // hold duration classification, long first
  assign dur       = in_now_q - press_start_q;
  assign released  = !pressed && was_pressed_q;
  assign long_hit  = released && (dur >= TIME_W'(cfg.long_press_ms));
  assign short_hit = released && !long_hit && (dur >= TIME_W'(cfg.short_press_ms));

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_now_q    <= now_ms_i;
      in_btn_q    <= button_low_i;
      in_sample_q <= touch_sample_i;
    end
  end

  // control and press state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_RUN;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      was_pressed_q <= 1'b0;
      press_start_q <= '0;
      last_touch_q  <= '0;
      eff_thr_q     <= RST_TOUCH_THR;
      calib_sum_q   <= '0;
      calib_cnt_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      case (state_q)
        ST_RUN: begin
          if (advance) begin
            was_pressed_q <= pressed;
            last_touch_q  <= touch_next;
            if (pressed && !was_pressed_q) begin
              press_start_q <= in_now_q;
            end
            if (calib_done) begin
              calib_sum_q <= '0;
              calib_cnt_q <= '0;
              out_valid_q <= 1'b0;
              state_q     <= ST_DIV;
            end else begin
              if (calib_now) begin
                calib_sum_q <= sum_new;
                calib_cnt_q <= cnt_new;
              end
              out_valid_q <= 1'b1;
            end
          end else begin
            if (out_ready_i) begin
              out_valid_q <= 1'b0;
            end
            // new threshold, let the release level follow before the next item
            if (thr_wr.wr) begin
              eff_thr_q   <= thr_wr.value;
              calib_sum_q <= '0;
              calib_cnt_q <= '0;
              state_q     <= ST_SETTLE;
            end
          end
        end
        ST_DIV: begin
          eff_thr_q   <= div_thr;
          out_valid_q <= 1'b1;
          state_q     <= ST_SETTLE;
        end
        ST_SETTLE: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (thr_wr.wr) begin
            eff_thr_q   <= thr_wr.value;
            calib_sum_q <= '0;
            calib_cnt_q <= '0;
          end else begin
            state_q <= ST_RUN;
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  // result payload; a calibration result gets its threshold in the following ST_DIV cycle
  always_ff @(posedge clk_i) begin
    if (advance) begin
      fin_sum_q     <= sum_new;
      out_short_q   <= short_hit;
      out_long_q    <= long_hit;
      out_pressed_q <= pressed;
      out_touch_q   <= touch_next;
      out_calib_q   <= calib_now;
      out_thr_q     <= eff_thr_q;
    end else if (state_q == ST_DIV) begin
      out_thr_q <= div_thr;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign short_press_o      = out_short_q;
  assign long_press_o       = out_long_q;
  assign pressed_now_o      = out_pressed_q;
  assign touch_level_o      = out_touch_q;
  assign calibrating_o      = out_calib_q;
  assign active_threshold_o = out_thr_q;

endmodule
